### rtl/core/color_palette_hash_allocator_assert.svh
// Assertion macros used by the palette allocator checker
`ifndef COLOR_PALETTE_HASH_ALLOCATOR_ASSERT_SVH
`define COLOR_PALETTE_HASH_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define CPH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define CPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cph_pkg.sv
// Package: sizes, codes and shared types of the palette slot allocator
`timescale 1ns / 1ps
`default_nettype none

package cph_pkg;

  // Table geometry (prime number of slots)
  localparam int unsigned TABLE_SIZE = 241;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);

  // Colour and result widths
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned COLOR_W = 3 * COMP_W;
  localparam int unsigned IDX_W   = 8;

  // Largest slot number seen on the result port
  localparam int unsigned IDX_MAX = (TABLE_SIZE - 1 > 255) ? 255 : TABLE_SIZE - 1;

  // Hash weights and the width of the weighted sum
  localparam int unsigned HASH_R = 67;
  localparam int unsigned HASH_G = 59;
  localparam int unsigned HASH_B = 71;
  localparam int unsigned SUM_MAX = (HASH_R + HASH_G + HASH_B) * ((1 << COMP_W) - 1);
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);

  // Home slot reduction: bits above the slot width fold back in with weight
  // FOLD_K, since 2^SLOT_W mod TABLE_SIZE equals FOLD_K
  localparam int unsigned HI_W   = SUM_W - SLOT_W;
  localparam int unsigned FOLD_K = (1 << SLOT_W) - TABLE_SIZE;

  // Constants in slot arithmetic width
  localparam logic [SLOT_W:0]   SIZE_EXT   = (SLOT_W + 1)'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W-1:0] LAST_PROBE = SLOT_W'(TABLE_SIZE - 2);

  // Request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NEW     = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
  } entry_t;

  // Hash unit status towards the controller
  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] home;
  } hash_status_t;

endpackage

`default_nettype wire

### rtl/core/color_palette_hash_allocator.sv
// Palette slot allocator: request control, probe sequencer and slot memory
//
// Hands out palette slots for 24-bit colours from an open-addressed table of
// TABLE_SIZE slots (241), probed quadratically from home = (67r+59g+71b) mod
// size. For a lookup, the hash folds the weighted sum down to the slot width
// (no fold for sums below 256) and ends with one compare and subtract, then
// the slot memory is read once per probe with the next probe address read
// ahead, probing 1 up to TABLE_SIZE-1 slots. With the output register free,
// the next request can be taken in the same cycle as the result appears. A
// clear request sweeps the slot memory one entry per cycle. After reset the
// same sweep runs once before the first request is taken. One request is in
// work at a time; a new request is taken while the previous result still
// waits in the output register, and a finished request holds until that
// register is free.
`timescale 1ns / 1ps
`default_nettype none

module color_palette_hash_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        req_type,
  input  wire logic [cph_pkg::COMP_W-1:0]  red,
  input  wire logic [cph_pkg::COMP_W-1:0]  green,
  input  wire logic [cph_pkg::COMP_W-1:0]  blue,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cph_pkg::IDX_W-1:0]        slot_index,
  output logic [1:0]                       status
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t                          state;
  logic [cph_pkg::SLOT_W-1:0]      sweep_addr;
  logic [cph_pkg::COLOR_W-1:0]     color_q;
  logic [cph_pkg::SLOT_W-1:0]      slot;
  logic [cph_pkg::SLOT_W-1:0]      step;
  logic [cph_pkg::SLOT_W-1:0]      probe_cnt;
  logic [cph_pkg::SLOT_W-1:0]      res_slot;
  cph_pkg::status_t                res_status;

  logic                            accept;
  logic                            hash_start;
  cph_pkg::hash_status_t           hstat;
  logic                            sweeping;

  logic [cph_pkg::SLOT_W:0]        slot_sum;
  logic [cph_pkg::SLOT_W-1:0]      slot_next;
  logic [cph_pkg::SLOT_W:0]        step_sum;
  logic [cph_pkg::SLOT_W-1:0]      step_next;

  logic                            ram_we;
  logic [cph_pkg::SLOT_W-1:0]      ram_waddr;
  cph_pkg::entry_t                 ram_wdata;
  logic [cph_pkg::SLOT_W-1:0]      ram_raddr;
  cph_pkg::entry_t                 ram_rdata;
  logic                            hit;

  // Request handshake
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign hash_start = accept && (req_type == cph_pkg::REQ_LOOKUP);

  cph_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .red   (red),
    .green (green),
    .blue  (blue),
    .hstat (hstat)
  );

  // Advance the quadratic probe: next slot and the step raised by two, both mod size
  always_comb begin
    slot_sum  = {1'b0, slot} + {1'b0, step};
    slot_next = (slot_sum >= cph_pkg::SIZE_EXT)
              ? cph_pkg::SLOT_W'(slot_sum - cph_pkg::SIZE_EXT)
              : cph_pkg::SLOT_W'(slot_sum);
    step_sum  = {1'b0, step} + (cph_pkg::SLOT_W + 1)'(2);
    step_next = (step_sum >= cph_pkg::SIZE_EXT)
              ? cph_pkg::SLOT_W'(step_sum - cph_pkg::SIZE_EXT)
              : cph_pkg::SLOT_W'(step_sum);
  end

  // Slot memory access: read ahead the next probe, write on claim or sweep
  assign sweeping  = (state == S_INIT) || (state == S_CLEAR);
  assign hit       = ram_rdata.valid && (ram_rdata.color == color_q);
  assign ram_raddr = (state == S_HASH) ? hstat.home : slot_next;
  assign ram_we    = sweeping || ((state == S_PROBE) && !ram_rdata.valid);
  assign ram_waddr = sweeping ? sweep_addr : slot;

  always_comb begin
    ram_wdata.valid = !sweeping;
    ram_wdata.color = color_q;
  end

  cph_ram #(
    .DEPTH (cph_pkg::TABLE_SIZE),
    .WIDTH ($bits(cph_pkg::entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (sweep_addr == cph_pkg::LAST_SLOT) begin
            sweep_addr <= '0;
            state      <= S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            color_q <= {red, green, blue};
            if (req_type == cph_pkg::REQ_CLEAR) begin
              sweep_addr <= '0;
              state      <= S_CLEAR;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hstat.done) begin
            slot      <= hstat.home;
            step      <= cph_pkg::SLOT_W'(1);
            probe_cnt <= '0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          priority if (!ram_rdata.valid) begin
            res_slot   <= slot;
            res_status <= cph_pkg::ST_NEW;
            state      <= S_DONE;
          end else if (hit) begin
            res_slot   <= slot;
            res_status <= cph_pkg::ST_FOUND;
            state      <= S_DONE;
          end else if (probe_cnt == cph_pkg::LAST_PROBE) begin
            res_slot   <= '0;
            res_status <= cph_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            slot      <= slot_next;
            step      <= step_next;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        S_CLEAR: begin
          if (sweep_addr == cph_pkg::LAST_SLOT) begin
            sweep_addr <= '0;
            res_slot   <= '0;
            res_status <= cph_pkg::ST_CLEARED;
            state      <= S_DONE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            slot_index <= cph_pkg::IDX_W'(res_slot);
            status     <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/cph_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module cph_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/cph_hash.sv
// Home slot hash: weighted colour sum reduced modulo the table size
`timescale 1ns / 1ps
`default_nettype none

module cph_hash (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [cph_pkg::COMP_W-1:0]    red,
  input  wire logic [cph_pkg::COMP_W-1:0]    green,
  input  wire logic [cph_pkg::COMP_W-1:0]    blue,
  output cph_pkg::hash_status_t              hstat
);

  logic                         busy;
  logic                         done;
  logic [cph_pkg::SUM_W-1:0]    rem;
  logic [cph_pkg::SUM_W-1:0]    wsum;
  logic [cph_pkg::HI_W-1:0]     rem_hi;
  logic [cph_pkg::SUM_W-1:0]    folded;
  logic                         fold_done;

  // Weighted sum of the three components
  assign wsum = cph_pkg::SUM_W'(red)   * cph_pkg::SUM_W'(cph_pkg::HASH_R)
              + cph_pkg::SUM_W'(green) * cph_pkg::SUM_W'(cph_pkg::HASH_G)
              + cph_pkg::SUM_W'(blue)  * cph_pkg::SUM_W'(cph_pkg::HASH_B);

  // Fold the part above the slot width back in, weighted by 2^SLOT_W mod size
  assign rem_hi    = rem[cph_pkg::SUM_W-1:cph_pkg::SLOT_W];
  assign fold_done = (rem_hi == '0);
  assign folded    = cph_pkg::SUM_W'(rem_hi) * cph_pkg::SUM_W'(cph_pkg::FOLD_K)
                   + cph_pkg::SUM_W'(rem[cph_pkg::SLOT_W-1:0]);

  // Load the sum, fold until it fits the slot width, then at most one final subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && fold_done;
      if (start) begin
        busy <= 1'b1;
        rem  <= wsum;
      end else if (busy) begin
        if (!fold_done) begin
          rem <= folded;
        end else begin
          // Below 2^SLOT_W, so at most one subtract of the size remains
          if (rem >= cph_pkg::SUM_W'(cph_pkg::TABLE_SIZE)) begin
            rem <= rem - cph_pkg::SUM_W'(cph_pkg::TABLE_SIZE);
          end
          busy <= 1'b0;
        end
      end
    end
  end

  assign hstat.done = done;
  assign hstat.home = rem[cph_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

### rtl/core/cph_chk.sv
// Port checker for the palette slot allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "color_palette_hash_allocator_assert.svh"

module cph_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        req_type,
  input wire logic [cph_pkg::COMP_W-1:0]  red,
  input wire logic [cph_pkg::COMP_W-1:0]  green,
  input wire logic [cph_pkg::COMP_W-1:0]  blue,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cph_pkg::IDX_W-1:0]   slot_index,
  input wire logic [1:0]                  status
);

  logic color_seen;

  // Colour fields are only meaningful on lookups
  assign color_seen = (req_type == cph_pkg::REQ_LOOKUP) && (|{red, green, blue} || 1'b1);

  // Hold a stalled result steady
  `CPH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(slot_index) && $stable(status), "stalled result changed")

  // One request in work at a time, checked on accepted lookups
  `CPH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && color_seen,
    !in_ready, "request taken while busy")

  // Full and cleared results carry slot zero
  `CPH_ASSERT_NOW(a_zero_slot,
    out_valid && (status == cph_pkg::ST_FULL || status == cph_pkg::ST_CLEARED),
    slot_index == '0, "full or cleared result with nonzero slot")

  // Found and new results name a slot inside the table
  `CPH_ASSERT_NOW(a_slot_range,
    out_valid && (status == cph_pkg::ST_FOUND || status == cph_pkg::ST_NEW),
    slot_index <= cph_pkg::IDX_W'(cph_pkg::IDX_MAX), "slot outside table")

endmodule

bind color_palette_hash_allocator cph_chk u_cph_chk (.*);

`default_nettype wire

### dv/slot_tracker_pkg.sv
// Scoreboard that predicts and checks palette slot grants
`timescale 1ns / 1ps

package slot_tracker_pkg;
  import cph_pkg::*;

  // One expected result: slot number on the port and its status
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    status_t          status;
  } grant_t;

  // Home slot of a colour under the palette hash
  function automatic int unsigned home_of(logic [COLOR_W-1:0] color);
    return (HASH_R * color[2*COMP_W +: COMP_W] + HASH_G * color[COMP_W +: COMP_W] +
            HASH_B * color[0 +: COMP_W]) % TABLE_SIZE;
  endfunction

  class slot_tracker;
    logic [COLOR_W-1:0] slot_color [TABLE_SIZE];
    logic               slot_valid [TABLE_SIZE];
    grant_t             pending_grants [$];
    int unsigned        requests_seen;
    int unsigned        grants_checked;
    int unsigned        failures;
    int unsigned        status_count [4];

    function new();
      foreach (slot_valid[k]) slot_valid[k] = 1'b0;
      foreach (status_count[k]) status_count[k] = 0;
      requests_seen  = 0;
      grants_checked = 0;
      failures       = 0;
    endfunction

    // Count a failure, print only the first few
    function void report(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Work out the grant for one request and update the shadow table
    function grant_t allocate_slot(logic req, logic [COLOR_W-1:0] color);
      grant_t      g;
      int unsigned home;
      int unsigned slot;
      if (req == REQ_CLEAR) begin
        foreach (slot_valid[k]) slot_valid[k] = 1'b0;
        g.slot   = '0;
        g.status = ST_CLEARED;
        return g;
      end
      home = home_of(color);
      slot = home;
      // Walk the quadratic probe sequence, the wrap-around revisit left out
      for (int unsigned i = 1; i < TABLE_SIZE; i++) begin
        if (!slot_valid[slot]) begin
          slot_valid[slot] = 1'b1;
          slot_color[slot] = color;
          g.slot   = IDX_W'(slot);
          g.status = ST_NEW;
          return g;
        end
        if (slot_color[slot] == color) begin
          g.slot   = IDX_W'(slot);
          g.status = ST_FOUND;
          return g;
        end
        slot = (home + (i * i) % TABLE_SIZE) % TABLE_SIZE;
      end
      g.slot   = '0;
      g.status = ST_FULL;
      return g;
    endfunction

    // Note an accepted request and queue its expected grant
    function void note_request(logic req, logic [COMP_W-1:0] r, logic [COMP_W-1:0] gr,
                               logic [COMP_W-1:0] b);
      pending_grants.push_back(allocate_slot(req, {r, gr, b}));
      requests_seen++;
    endfunction

    // Compare an accepted result with the oldest expected grant
    function void check_grant(logic [IDX_W-1:0] slot, logic [1:0] st);
      grant_t want;
      if (pending_grants.size() == 0) begin
        report($sformatf("result with nothing pending: slot %0d status %0d", slot, st));
        return;
      end
      want = pending_grants.pop_front();
      grants_checked++;
      status_count[int'(want.status)]++;
      if (slot !== want.slot || st !== want.status)
        report($sformatf("grant %0d: expected slot %0d status %s, got slot %0d status %0d",
                         grants_checked, want.slot, want.status.name(), slot, st));
    endfunction

    // Flag grants that never arrived
    function void close_out();
      if (pending_grants.size() != 0)
        report($sformatf("%0d expected results never arrived", pending_grants.size()));
    endfunction
  endclass

endpackage

### dv/testbench.sv
// Testbench for the palette slot allocator: random paint requests against a shadow table
`timescale 1ns / 1ps

module testbench;
  import cph_pkg::*;
  import slot_tracker_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned IDLE_PCT     = 14;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_SIZE + 20;

  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] color;
  } paint_req_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               req_type   = REQ_LOOKUP;
  logic [COMP_W-1:0]  red        = '0;
  logic [COMP_W-1:0]  green      = '0;
  logic [COMP_W-1:0]  blue       = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [IDX_W-1:0]   slot_index;
  logic [1:0]         status;

  paint_req_t         request_q [$];
  slot_tracker        tracker;
  bit                 requests_done = 1'b0;
  bit                 calm          = 1'b0;
  int unsigned        quiet_cycles  = 0;

  color_palette_hash_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .slot_index (slot_index),
    .status     (status)
  );

  always #1 clk = ~clk;

  // Queue one request
  task automatic queue_request(logic kind, logic [COLOR_W-1:0] color);
    paint_req_t rq;
    rq.kind  = kind;
    rq.color = color;
    request_q.push_back(rq);
  endtask

  // Random colour whose hash lands on the given home slot
  function automatic logic [COLOR_W-1:0] color_at_home(int unsigned home);
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
    int unsigned       start;
    r     = COMP_W'($urandom);
    g     = COMP_W'($urandom);
    start = $urandom_range(255);
    for (int unsigned k = 0; k < 256; k++) begin
      b = COMP_W'(start + k);
      if (home_of({r, g, b}) == home) return {r, g, b};
    end
    return {r, g, 8'h00};
  endfunction

  // Directed requests, then random epochs each opened by a clear
  task automatic build_requests();
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] seen [$];
    int unsigned        directed;
    int unsigned        epoch_len;
    int unsigned        kind;
    int unsigned        pick;
    int unsigned        target;
    bit                 first_epoch;
    // extremes, repeats, pure primaries
    queue_request(REQ_LOOKUP, 24'h000000);
    queue_request(REQ_LOOKUP, 24'h000000);
    queue_request(REQ_LOOKUP, 24'hFFFFFF);
    queue_request(REQ_LOOKUP, 24'hFFFFFF);
    queue_request(REQ_LOOKUP, 24'hFF0000);
    queue_request(REQ_LOOKUP, 24'h00FF00);
    queue_request(REQ_LOOKUP, 24'h0000FF);
    // collisions on home slot zero, then a repeat found after several probes
    for (int k = 0; k < 4; k++) begin
      c = color_at_home(0);
      queue_request(REQ_LOOKUP, c);
    end
    queue_request(REQ_LOOKUP, c);
    // top slot and its repeat
    c = color_at_home(TABLE_SIZE - 1);
    queue_request(REQ_LOOKUP, c);
    queue_request(REQ_LOOKUP, c);
    // clear ignores its colour fields; a clear of an empty table too
    queue_request(REQ_CLEAR, 24'hFFFFFF);
    queue_request(REQ_LOOKUP, 24'h000000);
    queue_request(REQ_CLEAR, 24'h000000);
    queue_request(REQ_CLEAR, 24'h5A5A5A);
    queue_request(REQ_LOOKUP, c);
    directed    = request_q.size();
    first_epoch = 1'b1;
    while (request_q.size() < directed + RANDOM_ITEMS) begin
      // the first epoch is the longest one and never aims at one home slot
      epoch_len = first_epoch ? 330 : $urandom_range(150, 10);
      kind      = first_epoch ? 0 : $urandom_range(3);
      target    = $urandom_range(TABLE_SIZE - 1);
      first_epoch = 1'b0;
      queue_request(REQ_CLEAR, COLOR_W'($urandom));
      seen.delete();
      repeat (epoch_len) begin
        pick = $urandom_range(99);
        if (kind == 3 && pick < 70) begin
          c = color_at_home(target);
        end else if (pick < 45 || seen.size() == 0) begin
          c = COLOR_W'($urandom);
        end else if (pick < 75) begin
          c = seen[$urandom_range(seen.size() - 1)];
        end else if (pick < 90) begin
          c = color_at_home(home_of(seen[$urandom_range(seen.size() - 1)]));
        end else if (pick < 92) begin
          c = COLOR_W'($urandom);
          queue_request(REQ_CLEAR, c);
          seen.delete();
        end else begin
          c = {($urandom_range(1) ? 8'hFF : 8'h00), ($urandom_range(1) ? 8'hFF : 8'h00),
               ($urandom_range(1) ? 8'hFF : 8'h00)};
        end
        if (!(pick >= 90 && pick < 92 && !(kind == 3 && pick < 70))) begin
          queue_request(REQ_LOOKUP, c);
          seen.push_back(c);
        end
      end
    end
  endtask

  // Reset, run, drain and report
  initial begin : main_flow
    tracker = new();
    build_requests();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (requests_done);
    while (tracker.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.close_out();
    $display("Run covered %0d requests and checked %0d results:", tracker.requests_seen,
             tracker.grants_checked);
    $display("  %0d found, %0d new, %0d table full, %0d cleared; %0d failures",
             tracker.status_count[ST_FOUND], tracker.status_count[ST_NEW],
             tracker.status_count[ST_FULL], tracker.status_count[ST_CLEARED],
             tracker.failures);
    if (tracker.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Drive requests, idling now and then between them
  initial begin : request_driver
    paint_req_t rq;
    do @(posedge clk); while (rst);
    while (!requests_done) begin
      if (!in_valid || in_ready) begin
        if (request_q.size() == 0) begin
          in_valid      <= 1'b0;
          requests_done  = 1'b1;
        end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
          in_valid <= 1'b0;
        end else begin
          rq        = request_q.pop_front();
          in_valid <= 1'b1;
          req_type <= rq.kind;
          red      <= rq.color[2*COMP_W +: COMP_W];
          green    <= rq.color[COMP_W +: COMP_W];
          blue     <= rq.color[0 +: COMP_W];
        end
      end
      if (!requests_done) @(posedge clk);
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Watch both handshakes and guard against a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_request(req_type, red, green, blue);
      if (out_valid && out_ready) tracker.check_grant(slot_index, status);
      // Hold both sides busy through a long middle stretch
      calm <= (tracker.requests_seen >= 250) && (tracker.requests_seen < 400);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Timeout: %0d cycles without a handshake", quiet_cycles);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

endmodule
